// File: rtl/fpx_pkg.sv
// Package for the serial frame deframer with XOR payload checksum.
// Holds the phase and status codes, register indexes and the result type.
// No dependencies.
`default_nettype none

package fpx_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SENDER,
        PH_DEST,
        PH_TYPE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECKSUM,
        PH_END
    } t_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_END  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_BAD_SUM  = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_MAX_LENGTH   = 8'd34;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] sender_addr;
        logic [BYTE_W-1:0] dest_addr;
        logic [BYTE_W-1:0] node_type;
        logic [BYTE_W-1:0] frame_length;
        logic [1:0]        status;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/frame_parser_xor_checksum.sv
// Serial frame deframer with XOR payload checksum, top level.
// Depends on fpx_pkg.
//
// Takes one received byte per item, one item per cycle while o_in_stall is low,
// and parses frames of the form start, sender, dest, node type, length, payload,
// checksum, end. Each payload byte comes out as a result item of kind 0; the end
// byte yields one report item of kind 1 with the header fields and a status (ok,
// bad end byte, checksum mismatch); a length above max_length is reported at
// once with status too long. Every byte updates the parser state in the cycle it
// is accepted and any result is registered in the output register, or in the
// skid register when the output stalls. A one-entry skid register keeps input
// flowing while a result waits; o_in_stall rises only when both the output and
// the skid register are full. Configuration writes apply from the next byte on.
`default_nettype none

module frame_parser_xor_checksum
    import fpx_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_kind,
    output logic [BYTE_W-1:0]         o_payload_byte,
    output logic [BYTE_W-1:0]         o_sender_addr,
    output logic [BYTE_W-1:0]         o_dest_addr,
    output logic [BYTE_W-1:0]         o_node_type,
    output logic [BYTE_W-1:0]         o_frame_length,
    output logic [1:0]                o_status
);

    logic [BYTE_W-1:0] r_start_marker, r_end_marker, r_max_length;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sender, n_sender;
    logic [BYTE_W-1:0] r_dest, n_dest;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_length, n_length;
    logic [BYTE_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              r_sum_bad, n_sum_bad;

    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic              r_skid_valid, n_skid_valid;
    t_result           r_skid, n_skid;

    logic              in_accept;
    logic              out_free;
    logic              res_valid;
    t_result           res;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= RST_START_MARKER;
            r_end_marker   <= RST_END_MARKER;
            r_max_length   <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                CFG_MAX_LENGTH:   r_max_length   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next parser state
    always_comb begin
        n_phase      = r_phase;
        n_sender     = r_sender;
        n_dest       = r_dest;
        n_type       = r_type;
        n_length     = r_length;
        n_bytes_left = r_bytes_left;
        n_xor        = r_xor;
        n_sum_bad    = r_sum_bad;
        if (in_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_start_marker) begin
                        n_phase   = PH_SENDER;
                        n_xor     = '0;
                        n_sum_bad = 1'b0;
                    end
                end
                PH_SENDER: begin
                    n_sender = i_rx_byte;
                    n_phase  = PH_DEST;
                end
                PH_DEST: begin
                    n_dest  = i_rx_byte;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_length = i_rx_byte;
                    n_xor    = '0;
                    if (i_rx_byte > r_max_length) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_bytes_left = i_rx_byte;
                        n_phase = (i_rx_byte == '0) ? PH_CHECKSUM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_xor        = r_xor ^ i_rx_byte;
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (r_bytes_left == 8'd1) begin
                        n_phase = PH_CHECKSUM;
                    end
                end
                PH_CHECKSUM: begin
                    n_sum_bad = (i_rx_byte != r_xor);
                    n_phase   = PH_END;
                end
                PH_END: begin
                    n_phase = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // result of the accepted byte
    always_comb begin
        res_valid        = 1'b0;
        res.kind         = KIND_REPORT;
        res.payload_byte = '0;
        res.sender_addr  = n_sender;
        res.dest_addr    = n_dest;
        res.node_type    = n_type;
        res.frame_length = n_length;
        res.status       = ST_OK;
        if (in_accept) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (i_rx_byte > r_max_length) begin
                        res_valid  = 1'b1;
                        res.status = ST_TOO_LONG;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = i_rx_byte;
                end
                PH_END: begin
                    res_valid = 1'b1;
                    if (i_rx_byte != r_end_marker) begin
                        res.status = ST_BAD_END;
                    end else if (r_sum_bad) begin
                        res.status = ST_BAD_SUM;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register and skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out       = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_sender     <= '0;
            r_dest       <= '0;
            r_type       <= '0;
            r_length     <= '0;
            r_bytes_left <= '0;
            r_xor        <= '0;
            r_sum_bad    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_sender     <= n_sender;
            r_dest       <= n_dest;
            r_type       <= n_type;
            r_length     <= n_length;
            r_bytes_left <= n_bytes_left;
            r_xor        <= n_xor;
            r_sum_bad    <= n_sum_bad;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_sender_addr  = r_out.sender_addr;
    assign o_dest_addr    = r_out.dest_addr;
    assign o_node_type    = r_out.node_type;
    assign o_frame_length = r_out.frame_length;
    assign o_status       = r_out.status;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while the output register is empty");

    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_PAYLOAD) |-> r_out.status == ST_OK)
        else $error("payload item with nonzero status");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != '0)
        else $error("payload phase with no bytes left");

    a_too_long_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_LENGTH && i_rx_byte > r_max_length)
        |=> r_phase == PH_HUNT)
        else $error("length error did not return to hunting");

endmodule

`default_nettype wire
